### rtl/cau_pkg.sv
package cau_pkg;

   // Word format: signed fixed point, Q16.16 by default
   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;

   // Derived widths
   localparam int PROD_BITS = 2 * WORD_BITS;       // full product, divisor, radicand
   localparam int SUM_BITS  = 2 * WORD_BITS + 1;   // sum of two products
   localparam int QUO_BITS  = WORD_BITS + 1;       // quotient bits kept before clamping
   localparam int LOW_BITS  = QUO_BITS - FRAC_BITS; // dividend bits fed from the numerator
   localparam int RREM_BITS = WORD_BITS + 1;       // square root remainder

   // Limits of a result word
   localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   // Opcodes
   localparam logic [3:0] OP_ADD  = 4'd0;
   localparam logic [3:0] OP_SUB  = 4'd1;
   localparam logic [3:0] OP_MUL  = 4'd2;
   localparam logic [3:0] OP_DIV  = 4'd3;
   localparam logic [3:0] OP_SADD = 4'd4;
   localparam logic [3:0] OP_SSUB = 4'd5;
   localparam logic [3:0] OP_SMUL = 4'd6;
   localparam logic [3:0] OP_SDIV = 4'd7;
   localparam logic [3:0] OP_CONJ = 4'd8;
   localparam logic [3:0] OP_MAG  = 4'd9;

   // Status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DIV0 = 2'd1;
   localparam logic [1:0] ST_SAT  = 2'd2;

   typedef struct packed {
      logic [3:0]                  action;
      logic signed [WORD_BITS-1:0] lhs_re;
      logic signed [WORD_BITS-1:0] lhs_im;
      logic signed [WORD_BITS-1:0] rhs_re;
      logic signed [WORD_BITS-1:0] rhs_im;
   } req_type;

   typedef struct packed {
      logic signed [WORD_BITS-1:0] out_re;
      logic signed [WORD_BITS-1:0] out_im;
      logic [1:0]                  status;
   } rsp_type;

   // Work carried through the divide / square root stages
   typedef struct packed {
      logic [3:0]           op;
      logic [WORD_BITS-1:0] simple_re;
      logic [WORD_BITS-1:0] simple_im;
      logic                 simple_sat;
      logic                 div_zero;
      logic [PROD_BITS-1:0] den;
      logic [PROD_BITS-1:0] re_rem;
      logic [PROD_BITS-1:0] im_rem;
      logic [QUO_BITS-1:0]  re_feed;
      logic [QUO_BITS-1:0]  im_feed;
      logic [QUO_BITS-1:0]  re_quo;
      logic [QUO_BITS-1:0]  im_quo;
      logic                 re_neg;
      logic                 im_neg;
      logic                 re_ovf;
      logic                 im_ovf;
      logic [PROD_BITS-1:0] rad;
      logic [RREM_BITS-1:0] root_rem;
      logic [WORD_BITS-1:0] root;
   } iter_type;

endpackage

### rtl/cau_iter_pipe.sv
module cau_iter_pipe
   import cau_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  iter_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output iter_type out_data
);

   localparam int NSTEP = QUO_BITS;

   iter_type stage_ff [0:NSTEP];
   iter_type stage_in [0:NSTEP];
   logic     valid_ff [0:NSTEP];
   logic     rdy      [0:NSTEP+1];

   assign stage_in[0] = in_data;
   assign rdy[NSTEP+1] = out_ready;

   // One quotient bit per lane per stage, one root bit per stage in the first WORD_BITS stages
   for (genvar k = 0; k < NSTEP; k++) begin : g_step
      always_comb begin
         logic [PROD_BITS:0]   re_t;
         logic [PROD_BITS:0]   im_t;
         logic [PROD_BITS:0]   den_t;
         logic [RREM_BITS+1:0] sq_t;
         logic [RREM_BITS+1:0] sq_test;
         logic                 re_ge;
         logic                 im_ge;
         logic                 sq_ge;
         stage_in[k+1] = stage_ff[k];
         den_t = {1'b0, stage_ff[k].den};
         re_t  = {stage_ff[k].re_rem, stage_ff[k].re_feed[QUO_BITS-1]};
         im_t  = {stage_ff[k].im_rem, stage_ff[k].im_feed[QUO_BITS-1]};
         re_ge = re_t >= den_t;
         im_ge = im_t >= den_t;
         stage_in[k+1].re_rem  = re_ge ? PROD_BITS'(re_t - den_t) : re_t[PROD_BITS-1:0];
         stage_in[k+1].im_rem  = im_ge ? PROD_BITS'(im_t - den_t) : im_t[PROD_BITS-1:0];
         stage_in[k+1].re_quo  = {stage_ff[k].re_quo[QUO_BITS-2:0], re_ge};
         stage_in[k+1].im_quo  = {stage_ff[k].im_quo[QUO_BITS-2:0], im_ge};
         stage_in[k+1].re_feed = {stage_ff[k].re_feed[QUO_BITS-2:0], 1'b0};
         stage_in[k+1].im_feed = {stage_ff[k].im_feed[QUO_BITS-2:0], 1'b0};
         sq_t    = {stage_ff[k].root_rem, stage_ff[k].rad[PROD_BITS-1:PROD_BITS-2]};
         sq_test = {1'b0, stage_ff[k].root, 2'b01};
         sq_ge   = sq_t >= sq_test;
         if (k < WORD_BITS) begin
            stage_in[k+1].root_rem = sq_ge ? RREM_BITS'(sq_t - sq_test)
                                           : sq_t[RREM_BITS-1:0];
            stage_in[k+1].root     = {stage_ff[k].root[WORD_BITS-2:0], sq_ge};
            stage_in[k+1].rad      = {stage_ff[k].rad[PROD_BITS-3:0], 2'b00};
         end
      end
   end

   // Advance each stage when it is empty or its successor takes the item
   for (genvar k = 0; k <= NSTEP; k++) begin : g_stage
      assign rdy[k] = !valid_ff[k] || rdy[k+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            valid_ff[k] <= (k == 0) ? in_valid : valid_ff[(k == 0) ? 0 : k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = valid_ff[NSTEP];
   assign out_data  = stage_ff[NSTEP];

endmodule

### rtl/complex_arithmetic_unit_top.sv
// Complex-number ALU, signed Q16.16. One item in, one result out, in order. A new item can
// enter every clock cycle while the output is not stalled; each item passes through one
// input register, one multiply stage (six 32x32 products), one sum stage, a prepare stage,
// 33 divide stages that also hold the 32-step square root, and the output register. The
// divider produces one quotient bit per stage for real and imaginary parts in parallel.
// A stalled output holds only the stages behind it that are full.
module complex_arithmetic_unit_top
   import cau_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   function automatic logic signed [SUM_BITS-1:0] ext_w(input logic signed [WORD_BITS-1:0] x);
      return {{(SUM_BITS-WORD_BITS){x[WORD_BITS-1]}}, x};
   endfunction

   function automatic logic signed [SUM_BITS-1:0] ext_p(input logic signed [PROD_BITS-1:0] x);
      return {x[PROD_BITS-1], x};
   endfunction

   // Clamp a wide value to a word; top bit of the result is the saturation flag
   function automatic logic [WORD_BITS:0] clamp(input logic signed [SUM_BITS-1:0] x);
      logic [SUM_BITS-WORD_BITS:0] top;
      top = x[SUM_BITS-1:WORD_BITS-1];
      if (top == '0 || top == '1) begin
         return {1'b0, x[WORD_BITS-1:0]};
      end
      return {1'b1, x[SUM_BITS-1] ? WORD_MIN : WORD_MAX};
   endfunction

   // ---------------- stage 1: input register
   req_type s1_ff;
   logic    s1_valid_ff;
   logic    s1_ready;

   // ---------------- stage 2: products
   logic                        s2_valid_ff;
   logic                        s2_ready;
   logic [3:0]                  s2_op_ff;
   logic signed [WORD_BITS-1:0] s2_a_ff, s2_b_ff, s2_c_ff, s2_d_ff;
   logic signed [PROD_BITS-1:0] p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [PROD_BITS-1:0] p0_in, p1_in, p2_in, p3_in, p4_in, p5_in;
   logic signed [WORD_BITS-1:0] m0_rhs, m1_rhs;
   logic                        s1_mag;

   // ---------------- stage 3: sums
   logic                        s3_valid_ff;
   logic                        s3_ready;
   logic [3:0]                  s3_op_ff;
   logic signed [SUM_BITS-1:0]  re_w_ff, im_w_ff, re_w_in, im_w_in;
   logic [PROD_BITS-1:0]        den_ff, den_in;
   logic                        cneg_ff, cneg_in;

   // ---------------- divide pipe and output
   iter_type iter_in, iter_out;
   logic     iter_ready, iter_out_valid, iter_out_ready;
   rsp_type  rsp_ff, rsp_in;
   logic     rsp_valid_ff;

   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s3_ready  = !s3_valid_ff || iter_ready;
   assign req_ready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= req_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   // Hold the accepted item
   always_ff @(posedge clock) begin
      if (s1_ready) s1_ff <= req_data;
   end

   // Multiply: magnitude squares lhs through the first two multipliers
   assign s1_mag = s1_ff.action == OP_MAG;
   assign m0_rhs = s1_mag ? s1_ff.lhs_re : s1_ff.rhs_re;
   assign m1_rhs = s1_mag ? s1_ff.lhs_im : s1_ff.rhs_im;
   assign p0_in  = s1_ff.lhs_re * m0_rhs;
   assign p1_in  = s1_ff.lhs_im * m1_rhs;
   assign p2_in  = s1_ff.lhs_re * s1_ff.rhs_im;
   assign p3_in  = s1_ff.lhs_im * s1_ff.rhs_re;
   assign p4_in  = s1_ff.rhs_re * s1_ff.rhs_re;
   assign p5_in  = s1_ff.rhs_im * s1_ff.rhs_im;

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_op_ff <= s1_ff.action;
         s2_a_ff  <= s1_ff.lhs_re;
         s2_b_ff  <= s1_ff.lhs_im;
         s2_c_ff  <= s1_ff.rhs_re;
         s2_d_ff  <= s1_ff.rhs_im;
         p0_ff    <= p0_in;
         p1_ff    <= p1_in;
         p2_ff    <= p2_in;
         p3_ff    <= p3_in;
         p4_ff    <= p4_in;
         p5_ff    <= p5_in;
      end
   end

   // Sum per opcode; divides leave numerators and divisor for the divide pipe
   always_comb begin
      logic signed [SUM_BITS-1:0] t_re;
      logic signed [SUM_BITS-1:0] t_im;
      logic signed [SUM_BITS-1:0] t_den;
      re_w_in = '0;
      im_w_in = '0;
      den_in  = '0;
      cneg_in = 1'b0;
      t_re    = '0;
      t_im    = '0;
      t_den   = '0;
      case (s2_op_ff)
         OP_ADD: begin
            re_w_in = ext_w(s2_a_ff) + ext_w(s2_c_ff);
            im_w_in = ext_w(s2_b_ff) + ext_w(s2_d_ff);
         end
         OP_SUB: begin
            re_w_in = ext_w(s2_a_ff) - ext_w(s2_c_ff);
            im_w_in = ext_w(s2_b_ff) - ext_w(s2_d_ff);
         end
         OP_MUL: begin
            t_re    = ext_p(p0_ff) - ext_p(p1_ff);
            t_im    = ext_p(p2_ff) + ext_p(p3_ff);
            re_w_in = t_re >>> FRAC_BITS;
            im_w_in = t_im >>> FRAC_BITS;
         end
         OP_DIV: begin
            re_w_in = ext_p(p0_ff) + ext_p(p1_ff);
            im_w_in = ext_p(p3_ff) - ext_p(p2_ff);
            t_den   = ext_p(p4_ff) + ext_p(p5_ff);
            den_in  = t_den[PROD_BITS-1:0];
         end
         OP_SADD: begin
            re_w_in = ext_w(s2_a_ff) + ext_w(s2_c_ff);
            im_w_in = ext_w(s2_b_ff);
         end
         OP_SSUB: begin
            re_w_in = ext_w(s2_a_ff) - ext_w(s2_c_ff);
            im_w_in = ext_w(s2_b_ff);
         end
         OP_SMUL: begin
            re_w_in = ext_p(p0_ff) >>> FRAC_BITS;
            im_w_in = ext_p(p3_ff) >>> FRAC_BITS;
         end
         OP_SDIV: begin
            re_w_in = ext_w(s2_a_ff);
            im_w_in = ext_w(s2_b_ff);
            t_den   = s2_c_ff[WORD_BITS-1] ? -ext_w(s2_c_ff) : ext_w(s2_c_ff);
            den_in  = t_den[PROD_BITS-1:0];
            cneg_in = s2_c_ff[WORD_BITS-1];
         end
         OP_CONJ: begin
            re_w_in = ext_w(s2_a_ff);
            im_w_in = -ext_w(s2_b_ff);
         end
         OP_MAG: begin
            re_w_in = ext_p(p0_ff) + ext_p(p1_ff);
         end
         default: begin
            re_w_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_op_ff <= s2_op_ff;
         re_w_ff  <= re_w_in;
         im_w_ff  <= im_w_in;
         den_ff   <= den_in;
         cneg_ff  <= cneg_in;
      end
   end

   // Prepare: clamp simple results, split divides into sign, magnitude and first remainder, pass the radicand
   always_comb begin
      logic [WORD_BITS:0]         c_re;
      logic [WORD_BITS:0]         c_im;
      logic signed [SUM_BITS-1:0] abs_re;
      logic signed [SUM_BITS-1:0] abs_im;
      logic [PROD_BITS-1:0]       m_re;
      logic [PROD_BITS-1:0]       m_im;
      c_re   = clamp(re_w_ff);
      c_im   = clamp(im_w_ff);
      abs_re = re_w_ff[SUM_BITS-1] ? -re_w_ff : re_w_ff;
      abs_im = im_w_ff[SUM_BITS-1] ? -im_w_ff : im_w_ff;
      m_re   = abs_re[PROD_BITS-1:0];
      m_im   = abs_im[PROD_BITS-1:0];
      iter_in            = '0;
      iter_in.op         = s3_op_ff;
      iter_in.simple_re  = c_re[WORD_BITS-1:0];
      iter_in.simple_im  = c_im[WORD_BITS-1:0];
      iter_in.simple_sat = c_re[WORD_BITS] || c_im[WORD_BITS];
      iter_in.div_zero   = den_ff == '0;
      iter_in.den        = den_ff;
      iter_in.re_neg     = re_w_ff[SUM_BITS-1] ^ cneg_ff;
      iter_in.im_neg     = im_w_ff[SUM_BITS-1] ^ cneg_ff;
      iter_in.re_ovf     = {{LOW_BITS{1'b0}}, m_re} >= {den_ff, {LOW_BITS{1'b0}}};
      iter_in.im_ovf     = {{LOW_BITS{1'b0}}, m_im} >= {den_ff, {LOW_BITS{1'b0}}};
      iter_in.re_rem     = m_re >> LOW_BITS;
      iter_in.im_rem     = m_im >> LOW_BITS;
      iter_in.re_feed    = {m_re[LOW_BITS-1:0], {FRAC_BITS{1'b0}}};
      iter_in.im_feed    = {m_im[LOW_BITS-1:0], {FRAC_BITS{1'b0}}};
      iter_in.rad        = re_w_ff[PROD_BITS-1:0];
   end

   cau_iter_pipe u_iter (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_ready  (iter_ready),
      .in_data   (iter_in),
      .out_valid (iter_out_valid),
      .out_ready (iter_out_ready),
      .out_data  (iter_out)
   );

   // Select and clamp the final result
   always_comb begin
      logic                 re_sat;
      logic                 im_sat;
      logic [WORD_BITS-1:0] q_re;
      logic [WORD_BITS-1:0] q_im;
      re_sat = iter_out.re_ovf ||
               (iter_out.re_neg ? iter_out.re_quo > {1'b0, WORD_MIN}
                                : iter_out.re_quo > {1'b0, WORD_MAX});
      im_sat = iter_out.im_ovf ||
               (iter_out.im_neg ? iter_out.im_quo > {1'b0, WORD_MIN}
                                : iter_out.im_quo > {1'b0, WORD_MAX});
      q_re = iter_out.re_neg ? -iter_out.re_quo[WORD_BITS-1:0] : iter_out.re_quo[WORD_BITS-1:0];
      q_im = iter_out.im_neg ? -iter_out.im_quo[WORD_BITS-1:0] : iter_out.im_quo[WORD_BITS-1:0];
      rsp_in = '0;
      case (iter_out.op)
         OP_DIV, OP_SDIV: begin
            if (iter_out.div_zero) begin
               rsp_in.status = ST_DIV0;
            end else begin
               rsp_in.out_re = re_sat ? (iter_out.re_neg ? WORD_MIN : WORD_MAX) : q_re;
               rsp_in.out_im = im_sat ? (iter_out.im_neg ? WORD_MIN : WORD_MAX) : q_im;
               rsp_in.status = (re_sat || im_sat) ? ST_SAT : ST_OK;
            end
         end
         OP_MAG: begin
            rsp_in.out_re = iter_out.root[WORD_BITS-1] ? WORD_MAX : iter_out.root;
            rsp_in.status = iter_out.root[WORD_BITS-1] ? ST_SAT : ST_OK;
         end
         default: begin
            rsp_in.out_re = iter_out.simple_re;
            rsp_in.out_im = iter_out.simple_im;
            rsp_in.status = iter_out.simple_sat ? ST_SAT : ST_OK;
         end
      endcase
   end

   // Output register: load when empty or taken
   assign iter_out_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (iter_out_ready) begin
         rsp_valid_ff <= iter_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (iter_out_ready) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_div0_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == ST_DIV0 |-> rsp_ff.out_re == '0 && rsp_ff.out_im == '0)
      else $error("divide by zero result is not zero");

   a_sat_limit : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == ST_SAT |->
         rsp_ff.out_re == WORD_MAX || rsp_ff.out_re == WORD_MIN ||
         rsp_ff.out_im == WORD_MAX || rsp_ff.out_im == WORD_MIN)
      else $error("saturated result has no part at a limit");

   a_status_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.status != 2'd3)
      else $error("undefined status code");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !s1_valid_ff)
      else $error("pipeline holds an item after reset");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import cau_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   complex_arithmetic_unit_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   localparam int LATENCY = 38;
   localparam logic signed [31:0] QMAX = 32'sh7fffffff;
   localparam logic signed [31:0] QMIN = 32'sh80000000;
   localparam logic signed [31:0] ONE = 32'sh00010000;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

   rsp_type    expected_rsp[$];
   int         errors = 0;
   int         results_seen = 0;
   int         items_sent = 0;
   int         send_pct = 0;
   int         recv_pct = 0;
   bit         hold_recv = 0;
   bit         stim_done = 0;

   // clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // report one mismatch
   task automatic report_mismatch(input string what, input rsp_type got, input rsp_type exp);
      $display("mismatch %s: got re=%h im=%h st=%0d exp re=%h im=%h st=%0d", what,
               got.out_re, got.out_im, got.status, exp.out_re, exp.out_im, exp.status);
      errors++;
   endtask

   // clamp a wide value to a word
   function automatic logic signed [31:0] clamp_word(input logic signed [127:0] v,
                                                     inout bit sat);
      if (v > 128'sh7fffffff) begin
         sat = 1;
         return QMAX;
      end
      if (v < -128'sh80000000) begin
         sat = 1;
         return QMIN;
      end
      return v[31:0];
   endfunction

   // (n << 16) / d, truncating toward zero; d positive
   function automatic logic signed [127:0] quo_trunc(input logic signed [127:0] n,
                                                     input logic signed [127:0] d);
      logic signed [127:0] m;
      logic signed [127:0] q;
      m = (n < 0) ? -n : n;
      q = (m <<< 16) / d;
      return (n < 0) ? -q : q;
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [127:0] v);
      logic [63:0]  r;
      logic [63:0]  t;
      logic [127:0] sq;
      r = 0;
      for (int b = 63; b >= 0; b--) begin
         t = r | (64'd1 << b);
         sq = {64'd0, t} * {64'd0, t};
         if (sq <= v) r = t;
      end
      return r;
   endfunction

   // compute the result of one item
   function automatic rsp_type alu_result(input req_type q);
      logic signed [127:0] a, b, c, d, re, im, den;
      logic [1:0]          st;
      bit                  sat;
      rsp_type             r;
      a = q.lhs_re; b = q.lhs_im; c = q.rhs_re; d = q.rhs_im;
      re = 0; im = 0; st = ST_OK; sat = 0;
      case (q.action)
         OP_ADD: begin re = a + c; im = b + d; end
         OP_SUB: begin re = a - c; im = b - d; end
         OP_MUL: begin re = (a*c - b*d) >>> 16; im = (a*d + b*c) >>> 16; end
         OP_DIV: begin
            den = c*c + d*d;
            if (den == 0) st = ST_DIV0;
            else begin
               re = quo_trunc(a*c + b*d, den);
               im = quo_trunc(b*c - a*d, den);
            end
         end
         OP_SADD: begin re = a + c; im = b; end
         OP_SSUB: begin re = a - c; im = b; end
         OP_SMUL: begin re = (a*c) >>> 16; im = (b*c) >>> 16; end
         OP_SDIV: begin
            if (c == 0) st = ST_DIV0;
            else begin
               den = (c < 0) ? -c : c;
               re = quo_trunc((c < 0) ? -a : a, den);
               im = quo_trunc((c < 0) ? -b : b, den);
            end
         end
         OP_CONJ: begin re = a; im = -b; end
         OP_MAG: re = {64'd0, int_sqrt(a*a + b*b)};
         default: ;
      endcase
      r.out_re = clamp_word(re, sat);
      r.out_im = clamp_word(im, sat);
      r.status = (st == ST_OK && sat) ? ST_SAT : st;
      return r;
   endfunction

   function automatic logic signed [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return QMAX - $urandom_range(0, 3);
         1: return QMIN + $urandom_range(0, 3);
         2: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
         3: return $signed($urandom_range(0, 3)) * ONE;
         default: return $urandom;
      endcase
   endfunction

   // hand one item to the block, honoring the sender idle rate
   task automatic send_item(input req_type q);
      while ($urandom_range(0, 99) < send_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_rsp.push_back(alu_result(q));
      items_sent++;
      @(negedge clock);
   endtask

   // drop valid and wait until every result is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (expected_rsp.size() != 0) @(negedge clock);
   endtask

   // receiver: stall at random or hold off on request
   always @(negedge clock) begin
      if (reset || hold_recv) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(0, 99) >= recv_pct);
   end

   // check each result against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            $display("unexpected item re=%h im=%h st=%0d",
                     rsp_data.out_re, rsp_data.out_im, rsp_data.status);
            errors++;
         end else begin
            rsp_type exp;
            exp = expected_rsp.pop_front();
            if (rsp_data.out_re !== exp.out_re) report_mismatch("out_re", rsp_data, exp);
            if (rsp_data.out_im !== exp.out_im) report_mismatch("out_im", rsp_data, exp);
            if (rsp_data.status !== exp.status) report_mismatch("status", rsp_data, exp);
         end
         results_seen++;
      end
   end

   // directed table: action, operands, and a typed-in result where obvious
   typedef struct {
      logic [3:0]        act;
      logic signed [31:0] ar, ai, br, bi;
      bit                 typed;
      rsp_type            res;
   } row_t;

   row_t rows[$];

   function automatic row_t mk(input logic [3:0] act, input logic signed [31:0] ar, ai, br, bi,
                               input bit typed = 0, input logic signed [31:0] er = 0,
                               input logic signed [31:0] ei = 0, input logic [1:0] es = ST_OK);
      row_t r;
      r.act = act; r.ar = ar; r.ai = ai; r.br = br; r.bi = bi;
      r.typed = typed; r.res = '{er, ei, es};
      return r;
   endfunction

   initial begin
      req_type q;
      rsp_type chk;
      int      k;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      repeat (12) @(negedge clock);
      reset = 1'b0;

      rows.push_back(mk(OP_ADD, ONE, ONE, ONE, -ONE, 1, 2*ONE, 0, ST_OK));
      rows.push_back(mk(OP_ADD, QMAX, QMIN, ONE, -ONE, 1, QMAX, QMIN, ST_SAT));
      rows.push_back(mk(OP_SUB, QMIN, QMAX, ONE, -ONE, 1, QMIN, QMAX, ST_SAT));
      rows.push_back(mk(OP_SUB, 3*ONE, 2*ONE, ONE, ONE, 1, 2*ONE, ONE, ST_OK));
      rows.push_back(mk(OP_MUL, ONE, 0, 0, ONE, 1, 0, ONE, ST_OK));
      rows.push_back(mk(OP_MUL, QMIN, QMIN, QMIN, QMIN));
      rows.push_back(mk(OP_MUL, -1, 1, 1, 1));
      rows.push_back(mk(OP_DIV, ONE, ONE, 0, 0, 1, 0, 0, ST_DIV0));
      rows.push_back(mk(OP_DIV, ONE, 0, 0, ONE, 1, 0, -ONE, ST_OK));
      rows.push_back(mk(OP_DIV, QMAX, QMIN, 1, 0));
      rows.push_back(mk(OP_DIV, QMIN, QMIN, QMIN, QMIN));
      rows.push_back(mk(OP_DIV, -7, 3, 5, -2));
      rows.push_back(mk(OP_SADD, ONE, 5, ONE, QMAX, 1, 2*ONE, 5, ST_OK));
      rows.push_back(mk(OP_SSUB, QMIN, 5, 1, 0, 1, QMIN, 5, ST_SAT));
      rows.push_back(mk(OP_SMUL, QMAX, QMIN, QMIN, 0));
      rows.push_back(mk(OP_SMUL, -3, 3, 1, 0));
      rows.push_back(mk(OP_SDIV, ONE, ONE, 0, 7, 1, 0, 0, ST_DIV0));
      rows.push_back(mk(OP_SDIV, QMIN, QMAX, -1, 0));
      rows.push_back(mk(OP_SDIV, -5, 5, -ONE*3, 0));
      rows.push_back(mk(OP_CONJ, QMIN, QMIN, 0, 0, 1, QMIN, QMAX, ST_SAT));
      rows.push_back(mk(OP_CONJ, 7, -7, 0, 0, 1, 7, 7, ST_OK));
      rows.push_back(mk(OP_MAG, 3*ONE, 4*ONE, 9, 9, 1, 5*ONE, 0, ST_OK));
      rows.push_back(mk(OP_MAG, QMIN, QMIN, 0, 0, 1, QMAX, 0, ST_SAT));
      rows.push_back(mk(4'd10, ONE, ONE, ONE, ONE, 1, 0, 0, ST_OK));
      rows.push_back(mk(4'd15, QMIN, QMAX, -1, -1, 1, 0, 0, ST_OK));

      // walk the directed table, typed results checked against the predictor
      foreach (rows[i]) begin
         q = '{rows[i].act, rows[i].ar, rows[i].ai, rows[i].br, rows[i].bi};
         if (rows[i].typed) begin
            chk = alu_result(q);
            if (chk !== rows[i].res) report_mismatch("table", chk, rows[i].res);
         end
         send_item(q);
      end
      wait_drained();

      // random phases with different idle patterns
      for (int ph = IDLE_NONE; ph <= IDLE_BOTH; ph++) begin
         send_pct = (ph == IDLE_SEND) ? 73 : (ph == IDLE_BOTH) ? 31 : 0;
         recv_pct = (ph == IDLE_RECV) ? 73 : (ph == IDLE_BOTH) ? 31 : 0;
         if (ph == IDLE_RECV) begin
            hold_recv = 1;
            fork
               begin
                  for (k = 0; k < 150; k++) @(negedge clock);
                  hold_recv = 0;
               end
            join_none
         end
         for (int n = 0; n < 130; n++) begin
            q.action = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                                     : 4'($urandom_range(0, 9));
            q.lhs_re = rand_word();
            q.lhs_im = rand_word();
            q.rhs_re = ($urandom_range(0, 15) == 0) ? 32'sd0 : rand_word();
            q.rhs_im = ($urandom_range(0, 15) == 0) ? 32'sd0 : rand_word();
            send_item(q);
         end
         // pause until everything is back
         wait_drained();
      end

      repeat (LATENCY + 10) @(negedge clock);
      $display("ran %0d items over all ten operations, unused codes and four idle patterns",
               items_sent);
      $display("%0d results checked, %0d mismatches", results_seen, errors);
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("timeout");
      $display("== FAIL ==");
      $finish;
   end

endmodule
